// ----- rtl/rbr_pkg.sv -----
// ---------------------------------------------------------------------------
// rbr_pkg: shared definitions for the radial barrel remap address unit
// fixed field widths, configuration register indexes and reset values
// ---------------------------------------------------------------------------
package rbr_pkg;

  localparam int PIXEL_W   = 12;
  localparam int DIM_CFG_W = 13;
  localparam int COORD_W   = 13;
  localparam int INDEX_W   = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [DIM_CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_CFG_W-1:0] HEIGHT_RESET = 13'd480;

endpackage

// ----- rtl/rbr_div_cell.sv -----
// ---------------------------------------------------------------------------
// rbr_div_cell: one restoring division step
// brings down one numerator bit, subtracts the divisor if it fits
// ---------------------------------------------------------------------------
module rbr_div_cell #(
  parameter int DVW = 13,
  parameter int QW  = 18,
  parameter int TW  = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           i_valid,
  input  logic [DVW:0]   i_rem,
  input  logic [QW-1:0]  i_low,
  input  logic [QW-1:0]  i_quo,
  input  logic [DVW-1:0] i_dvs,
  input  logic [TW-1:0]  i_tag,
  output logic           o_valid,
  output logic [DVW:0]   o_rem,
  output logic [QW-1:0]  o_low,
  output logic [QW-1:0]  o_quo,
  output logic [DVW-1:0] o_dvs,
  output logic [TW-1:0]  o_tag
);

  logic [DVW:0]   rem_sh;
  logic [DVW+1:0] diff;
  logic           take;

  assign rem_sh = {i_rem[DVW-1:0], i_low[QW-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, i_dvs};
  assign take   = !diff[DVW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_rem <= take ? diff[DVW:0] : rem_sh;
      o_low <= {i_low[QW-2:0], 1'b0};
      o_quo <= {i_quo[QW-2:0], take};
      o_dvs <= i_dvs;
      o_tag <= i_tag;
    end
  end

endmodule

// ----- rtl/rbr_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// rbr_sqrt_cell: one digit-by-digit square root step
// takes two radicand bits and settles one root bit
// ---------------------------------------------------------------------------
module rbr_sqrt_cell #(
  parameter int M  = 17,
  parameter int TW = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           i_valid,
  input  logic [2*M-1:0] i_rad,
  input  logic [M+1:0]   i_rem,
  input  logic [M-1:0]   i_root,
  input  logic [TW-1:0]  i_tag,
  output logic           o_valid,
  output logic [2*M-1:0] o_rad,
  output logic [M+1:0]   o_rem,
  output logic [M-1:0]   o_root,
  output logic [TW-1:0]  o_tag
);

  logic [M+1:0] rem_sh;
  logic [M+1:0] trial;
  logic [M+2:0] diff;
  logic         take;

  assign rem_sh = {i_rem[M-1:0], i_rad[2*M-1 -: 2]};
  assign trial  = {i_root, 2'b01};
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};
  assign take   = !diff[M+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= i_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_rad  <= {i_rad[2*M-3:0], 2'b00};
      o_rem  <= take ? diff[M+1:0] : rem_sh;
      o_root <= {i_root[M-2:0], take};
      o_tag  <= i_tag;
    end
  end

endmodule

// ----- rtl/radial_barrel_remap_address_unit.sv -----
// ---------------------------------------------------------------------------
// radial_barrel_remap_address_unit: fisheye remap source address
// maps a destination pixel to the source pixel and linear index it reads
// ---------------------------------------------------------------------------
// One pixel coordinate is taken every cycle while the pipe is not held. Each
// passes through three chains of one-bit cells: the normalising divide
// (FRAC_BITS+2 cells), the two square roots side by side (FRAC_BITS+1 cells)
// and the direction divide (FRAC_BITS+1 cells), plus nine registered stages
// for the squares, products and the final index. The whole pipe moves on one
// enable: it advances whenever the output register is empty or being taken,
// so in_ready only drops while a finished result waits at the output.
// Image width and height are written through the cfg port and must only
// change while no pixel is in flight; zero is used as one and values above
// MAX_DIM as MAX_DIM.
// ---------------------------------------------------------------------------
module radial_barrel_remap_address_unit #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbr_pkg::DIM_CFG_W-1:0]     cfg_data,
  // destination pixel beats
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [rbr_pkg::PIXEL_W-1:0]       pixel_x,
  input  logic [rbr_pkg::PIXEL_W-1:0]       pixel_y,
  // source address beats
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              inside_res,
  output logic [rbr_pkg::COORD_W-1:0]       source_x,
  output logic [rbr_pkg::COORD_W-1:0]       source_y,
  output logic [rbr_pkg::INDEX_W-1:0]       source_index
);

  localparam int F  = FRAC_BITS;
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int S1 = F + 2;   // normalising divide steps
  localparam int M  = F + 1;   // root and direction divide steps
  localparam int TA = 3 + 2 * M;

  localparam logic [F+1:0]   ONE_Q  = {1'b0, 1'b1, {F{1'b0}}};
  localparam logic [F+1:0]   TWO_Q  = {1'b1, {(F+1){1'b0}}};
  localparam logic [2*F+2:0] ONE_SQ = {2'b00, 1'b1, {(2*F){1'b0}}};

  // global pipe enable
  logic en;

  // configuration registers
  logic [rbr_pkg::DIM_CFG_W-1:0] width_reg;
  logic [rbr_pkg::DIM_CFG_W-1:0] height_reg;
  logic [DW-1:0]                 wc;
  logic [DW-1:0]                 hc;
  logic [2*DW-1:0]               wh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= rbr_pkg::WIDTH_RESET;
      height_reg <= rbr_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        rbr_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
        rbr_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the sizes into 1..MAX_DIM
  logic [31:0] wide_w;
  logic [31:0] wide_h;

  always_comb begin
    wide_w = 32'(width_reg);
    wide_h = 32'(height_reg);
    if (width_reg == '0) begin
      wc = DW'(1);
    end else if (wide_w > 32'(MAX_DIM)) begin
      wc = DW'(MAX_DIM);
    end else begin
      wc = wide_w[DW-1:0];
    end
    if (height_reg == '0) begin
      hc = DW'(1);
    end else if (wide_h > 32'(MAX_DIM)) begin
      hc = DW'(MAX_DIM);
    end else begin
      hc = wide_h[DW-1:0];
    end
  end

  // image area for the index bound; the user must keep sizes stable while pixels fly, the block does not enforce it
  always_ff @(posedge clk) begin
    wh <= {{DW{1'b0}}, wc} * {{DW{1'b0}}, hc};
  end

  // ---- normalising divide: q = (2p << F) / d -----------------------------
  // p >= 2d would need more quotient bits, and lies outside the circle anyway
  logic [31:0] half_x;
  logic [31:0] half_y;
  logic        ovf_x;
  logic        ovf_y;

  assign half_x = 32'({1'b0, pixel_x[rbr_pkg::PIXEL_W-1:1]});
  assign half_y = 32'({1'b0, pixel_y[rbr_pkg::PIXEL_W-1:1]});
  assign ovf_x  = half_x >= 32'(wc);
  assign ovf_y  = half_y >= 32'(hc);

  logic          d1x_v   [0:S1];
  logic [DW:0]   d1x_rem [0:S1];
  logic [S1-1:0] d1x_low [0:S1];
  logic [S1-1:0] d1x_quo [0:S1];
  logic [DW-1:0] d1x_dvs [0:S1];
  logic [0:0]    d1x_tag [0:S1];
  logic          d1y_v   [0:S1];
  logic [DW:0]   d1y_rem [0:S1];
  logic [S1-1:0] d1y_low [0:S1];
  logic [S1-1:0] d1y_quo [0:S1];
  logic [DW-1:0] d1y_dvs [0:S1];
  logic [0:0]    d1y_tag [0:S1];

  assign d1x_v[0]   = in_valid;
  assign d1x_rem[0] = ovf_x ? '0 : half_x[DW:0];
  assign d1x_low[0] = {pixel_x[0], {(F+1){1'b0}}};
  assign d1x_quo[0] = '0;
  assign d1x_dvs[0] = wc;
  assign d1x_tag[0] = ovf_x;
  assign d1y_v[0]   = in_valid;
  assign d1y_rem[0] = ovf_y ? '0 : half_y[DW:0];
  assign d1y_low[0] = {pixel_y[0], {(F+1){1'b0}}};
  assign d1y_quo[0] = '0;
  assign d1y_dvs[0] = hc;
  assign d1y_tag[0] = ovf_y;

  for (genvar i = 0; i < S1; i++) begin : g_norm
    rbr_div_cell #(.DVW(DW), .QW(S1), .TW(1)) u_cell_x (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(d1x_v[i]), .i_rem(d1x_rem[i]), .i_low(d1x_low[i]),
      .i_quo(d1x_quo[i]), .i_dvs(d1x_dvs[i]), .i_tag(d1x_tag[i]),
      .o_valid(d1x_v[i+1]), .o_rem(d1x_rem[i+1]), .o_low(d1x_low[i+1]),
      .o_quo(d1x_quo[i+1]), .o_dvs(d1x_dvs[i+1]), .o_tag(d1x_tag[i+1])
    );
    rbr_div_cell #(.DVW(DW), .QW(S1), .TW(1)) u_cell_y (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(d1y_v[i]), .i_rem(d1y_rem[i]), .i_low(d1y_low[i]),
      .i_quo(d1y_quo[i]), .i_dvs(d1y_dvs[i]), .i_tag(d1y_tag[i]),
      .o_valid(d1y_v[i+1]), .o_rem(d1y_rem[i+1]), .o_low(d1y_low[i+1]),
      .o_quo(d1y_quo[i+1]), .o_dvs(d1y_dvs[i+1]), .o_tag(d1y_tag[i+1])
    );
  end

  // ---- stage a: signed normalised coordinate as sign and magnitude ------
  logic         a_valid;
  logic         a_out;
  logic         a_negx;
  logic         a_negy;
  logic [F:0]   a_magx;
  logic [F:0]   a_magy;
  logic         a_out_next;
  logic [F+1:0] qx_diff;
  logic [F+1:0] qy_diff;

  always_comb begin
    a_out_next = d1x_tag[S1][0] || d1y_tag[S1][0] ||
                 (d1x_quo[S1] > TWO_Q) || (d1y_quo[S1] > TWO_Q);
    qx_diff = (d1x_quo[S1] < ONE_Q) ? ONE_Q - d1x_quo[S1] : d1x_quo[S1] - ONE_Q;
    qy_diff = (d1y_quo[S1] < ONE_Q) ? ONE_Q - d1y_quo[S1] : d1y_quo[S1] - ONE_Q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= d1x_v[S1] && d1y_v[S1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_out  <= a_out_next;
      a_negx <= d1x_quo[S1] < ONE_Q;
      a_negy <= d1y_quo[S1] < ONE_Q;
      // keep magnitudes in range when the pixel is already out
      a_magx <= a_out_next ? '0 : qx_diff[F:0];
      a_magy <= a_out_next ? '0 : qy_diff[F:0];
    end
  end

  // ---- stage b: squares ----------------------------------------------------
  logic           b_valid;
  logic           b_out;
  logic           b_negx;
  logic           b_negy;
  logic [F:0]     b_magx;
  logic [F:0]     b_magy;
  logic [2*F+1:0] b_sqx;
  logic [2*F+1:0] b_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_out  <= a_out;
      b_negx <= a_negx;
      b_negy <= a_negy;
      b_magx <= a_magx;
      b_magy <= a_magy;
      b_sqx  <= {{(F+1){1'b0}}, a_magx} * {{(F+1){1'b0}}, a_magx};
      b_sqy  <= {{(F+1){1'b0}}, a_magy} * {{(F+1){1'b0}}, a_magy};
    end
  end

  // ---- stage c: radius squared, circle test, root operands -----------------
  logic           c_valid;
  logic           c_out;
  logic [TA-1:0]  c_tag;
  logic [2*M-1:0] c_rad_r;
  logic [2*M-1:0] c_rad_s;
  logic [2*F+2:0] r2_sum;
  logic [2*F+2:0] r2_rest;
  logic           c_out_next;

  assign r2_sum     = {1'b0, b_sqx} + {1'b0, b_sqy};
  assign r2_rest    = ONE_SQ - r2_sum;
  assign c_out_next = b_out || (r2_sum > ONE_SQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (en) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_out   <= c_out_next;
      c_tag   <= {c_out_next, b_negx, b_negy, b_magx, b_magy};
      c_rad_r <= c_out_next ? '0 : r2_sum[2*M-1:0];
      c_rad_s <= c_out_next ? '0 : r2_rest[2*M-1:0];
    end
  end

  // ---- root chains: r = sqrt(r2), s = sqrt(one^2 - r2) ---------------------
  logic           sr_v    [0:M];
  logic [2*M-1:0] sr_rad  [0:M];
  logic [M+1:0]   sr_rem  [0:M];
  logic [M-1:0]   sr_root [0:M];
  logic [TA-1:0]  sr_tag  [0:M];
  logic           ss_v    [0:M];
  logic [2*M-1:0] ss_rad  [0:M];
  logic [M+1:0]   ss_rem  [0:M];
  logic [M-1:0]   ss_root [0:M];
  logic [0:0]     ss_tag  [0:M];

  assign sr_v[0]    = c_valid;
  assign sr_rad[0]  = c_rad_r;
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;
  assign sr_tag[0]  = c_tag;
  assign ss_v[0]    = c_valid;
  assign ss_rad[0]  = c_rad_s;
  assign ss_rem[0]  = '0;
  assign ss_root[0] = '0;
  assign ss_tag[0]  = c_out;

  for (genvar i = 0; i < M; i++) begin : g_root
    rbr_sqrt_cell #(.M(M), .TW(TA)) u_cell_r (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(sr_v[i]), .i_rad(sr_rad[i]), .i_rem(sr_rem[i]),
      .i_root(sr_root[i]), .i_tag(sr_tag[i]),
      .o_valid(sr_v[i+1]), .o_rad(sr_rad[i+1]), .o_rem(sr_rem[i+1]),
      .o_root(sr_root[i+1]), .o_tag(sr_tag[i+1])
    );
    rbr_sqrt_cell #(.M(M), .TW(1)) u_cell_s (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(ss_v[i]), .i_rad(ss_rad[i]), .i_rem(ss_rem[i]),
      .i_root(ss_root[i]), .i_tag(ss_tag[i]),
      .o_valid(ss_v[i+1]), .o_rad(ss_rad[i+1]), .o_rem(ss_rem[i+1]),
      .o_root(ss_root[i+1]), .o_tag(ss_tag[i+1])
    );
  end

  // ---- stage d: new radius nr = (r + one - s) / 2 --------------------------
  logic         d_valid;
  logic         d_out;
  logic         d_negx;
  logic         d_negy;
  logic [F:0]   d_magx;
  logic [F:0]   d_magy;
  logic [M-1:0] d_nr;
  logic [M-1:0] d_r;
  logic         d_rz;
  logic [M:0]   nr_sum;

  assign nr_sum = {1'b0, sr_root[M]} + {1'b0, ONE_Q[F:0]} - {1'b0, ss_root[M]};

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (en) begin
      d_valid <= sr_v[M] && ss_v[M];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out  <= sr_tag[M][TA-1] || ss_tag[M][0];
      d_negx <= sr_tag[M][TA-2];
      d_negy <= sr_tag[M][TA-3];
      d_magx <= sr_tag[M][2*M-1:M];
      d_magy <= sr_tag[M][M-1:0];
      d_nr   <= nr_sum[M:1];
      d_r    <= sr_root[M];
      d_rz   <= sr_root[M] == '0;
    end
  end

  // ---- stage e: nr * |n| ---------------------------------------------------
  logic           e_valid;
  logic           e_out;
  logic           e_negx;
  logic           e_negy;
  logic           e_rz;
  logic [M-1:0]   e_r;
  logic [2*M-1:0] e_prodx;
  logic [2*M-1:0] e_prody;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (en) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_out   <= d_out;
      e_negx  <= d_negx;
      e_negy  <= d_negy;
      e_rz    <= d_rz;
      e_r     <= d_r;
      e_prodx <= {{M{1'b0}}, d_nr} * {{M{1'b0}}, d_magx};
      e_prody <= {{M{1'b0}}, d_nr} * {{M{1'b0}}, d_magy};
    end
  end

  // ---- direction divide: nr * |n| / r, quotient never above nr -------------
  logic         d2x_v   [0:M];
  logic [M:0]   d2x_rem [0:M];
  logic [M-1:0] d2x_low [0:M];
  logic [M-1:0] d2x_quo [0:M];
  logic [M-1:0] d2x_dvs [0:M];
  logic [2:0]   d2x_tag [0:M];
  logic         d2y_v   [0:M];
  logic [M:0]   d2y_rem [0:M];
  logic [M-1:0] d2y_low [0:M];
  logic [M-1:0] d2y_quo [0:M];
  logic [M-1:0] d2y_dvs [0:M];
  logic [0:0]   d2y_tag [0:M];

  assign d2x_v[0]   = e_valid;
  assign d2x_rem[0] = {2'b00, e_prodx[2*M-2:M]};
  assign d2x_low[0] = e_prodx[M-1:0];
  assign d2x_quo[0] = '0;
  assign d2x_dvs[0] = e_r;
  assign d2x_tag[0] = {e_out, e_negx, e_rz};
  assign d2y_v[0]   = e_valid;
  assign d2y_rem[0] = {2'b00, e_prody[2*M-2:M]};
  assign d2y_low[0] = e_prody[M-1:0];
  assign d2y_quo[0] = '0;
  assign d2y_dvs[0] = e_r;
  assign d2y_tag[0] = e_negy;

  for (genvar i = 0; i < M; i++) begin : g_dir
    rbr_div_cell #(.DVW(M), .QW(M), .TW(3)) u_cell_x (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(d2x_v[i]), .i_rem(d2x_rem[i]), .i_low(d2x_low[i]),
      .i_quo(d2x_quo[i]), .i_dvs(d2x_dvs[i]), .i_tag(d2x_tag[i]),
      .o_valid(d2x_v[i+1]), .o_rem(d2x_rem[i+1]), .o_low(d2x_low[i+1]),
      .o_quo(d2x_quo[i+1]), .o_dvs(d2x_dvs[i+1]), .o_tag(d2x_tag[i+1])
    );
    rbr_div_cell #(.DVW(M), .QW(M), .TW(1)) u_cell_y (
      .clk(clk), .rst(rst), .en(en),
      .i_valid(d2y_v[i]), .i_rem(d2y_rem[i]), .i_low(d2y_low[i]),
      .i_quo(d2y_quo[i]), .i_dvs(d2y_dvs[i]), .i_tag(d2y_tag[i]),
      .o_valid(d2y_v[i+1]), .o_rem(d2y_rem[i+1]), .o_low(d2y_low[i+1]),
      .o_quo(d2y_quo[i+1]), .o_dvs(d2y_dvs[i+1]), .o_tag(d2y_tag[i+1])
    );
  end

  // ---- stage g: back to unsigned n + one, centre when r is zero ------------
  logic         g_valid;
  logic         g_out;
  logic [F+1:0] g_ux;
  logic [F+1:0] g_uy;
  logic [M-1:0] dir_x;
  logic [M-1:0] dir_y;

  assign dir_x = d2x_tag[M][0] ? '0 : d2x_quo[M];
  assign dir_y = d2x_tag[M][0] ? '0 : d2y_quo[M];

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (en) begin
      g_valid <= d2x_v[M] && d2y_v[M];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_out <= d2x_tag[M][2];
      g_ux  <= d2x_tag[M][1] ? ONE_Q - {1'b0, dir_x} : ONE_Q + {1'b0, dir_x};
      g_uy  <= d2y_tag[M][0] ? ONE_Q - {1'b0, dir_y} : ONE_Q + {1'b0, dir_y};
    end
  end

  // ---- stage h: scale back to pixels --------------------------------------
  logic            h_valid;
  logic            h_out;
  logic [F+DW+1:0] h_px;
  logic [F+DW+1:0] h_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (en) begin
      h_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_out <= g_out;
      h_px  <= {{DW{1'b0}}, g_ux} * {{(F+2){1'b0}}, wc};
      h_py  <= {{DW{1'b0}}, g_uy} * {{(F+2){1'b0}}, hc};
    end
  end

  // ---- stage i: truncate, row offset ---------------------------------------
  logic            i_valid;
  logic            i_out;
  logic [DW-1:0]   i_sx;
  logic [DW-1:0]   i_sy;
  logic [2*DW-1:0] i_syw;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (en) begin
      i_valid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_out <= h_out;
      i_sx  <= h_px[F+DW:F+1];
      i_sy  <= h_py[F+DW:F+1];
      i_syw <= {{DW{1'b0}}, h_py[F+DW:F+1]} * {{DW{1'b0}}, wc};
    end
  end

  // ---- output register: linear index and bound check -----------------------
  logic [2*DW:0] pos;
  logic [63:0]   pos_wide;
  logic [63:0]   sx_wide;
  logic [63:0]   sy_wide;
  logic          ok;

  assign pos      = {1'b0, i_syw} + {{(DW+1){1'b0}}, i_sx};
  assign pos_wide = 64'(pos);
  assign sx_wide  = 64'(i_sx);
  assign sy_wide  = 64'(i_sy);
  assign ok       = !i_out && (pos < {1'b0, wh});

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= i_valid;
    end
  end

  // pixels outside the circle report a zero address
  always_ff @(posedge clk) begin
    if (en) begin
      inside_res   <= ok;
      source_x     <= i_out ? '0 : sx_wide[rbr_pkg::COORD_W-1:0];
      source_y     <= i_out ? '0 : sy_wide[rbr_pkg::COORD_W-1:0];
      source_index <= i_out ? '0 : pos_wide[rbr_pkg::INDEX_W-1:0];
    end
  end

  // ---- checks ---------------------------------------------------------------
  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid straight after reset");

  // the two root operands split one^2 between them inside the circle
  a_root_split: assert property (@(posedge clk) disable iff (rst)
    c_valid && !c_out |-> ({1'b0, c_rad_r} + {1'b0, c_rad_s}) == ONE_SQ[2*M:0])
    else $error("root operands do not sum to one squared");

  // the new radius never passes one
  a_nr_bound: assert property (@(posedge clk) disable iff (rst)
    d_valid |-> d_nr <= ONE_Q[F:0])
    else $error("new radius above one");

  // the remapped coordinate stays in 0..2*one
  a_dir_bound: assert property (@(posedge clk) disable iff (rst)
    g_valid && !g_out |-> g_ux <= TWO_Q && g_uy <= TWO_Q)
    else $error("remapped coordinate out of range");

  // an in-bound address taken into the output register comes out flagged inside
  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    en && i_valid && ok |=> out_valid && inside_res)
    else $error("in-bound address lost on its way out");

endmodule

// ----- test/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: radial barrel remap address unit
// drives destination pixels under several image sizes and checks every
// source address beat against its directed table row or an in-bench fixed-point fisheye predictor
// ---------------------------------------------------------------------------
module testbench;

  localparam int FRAC     = 16;
  localparam int DIM_MAX  = 4096;
  localparam int LATENCY  = 3*FRAC+13;

  typedef struct packed {
    logic                         hit;
    logic [rbr_pkg::COORD_W-1:0]  sx;
    logic [rbr_pkg::COORD_W-1:0]  sy;
    logic [rbr_pkg::INDEX_W-1:0]  idx;
  } addr_t;

  typedef struct {
    logic [rbr_pkg::PIXEL_W-1:0] px;
    logic [rbr_pkg::PIXEL_W-1:0] py;
    bit                          typed;   // expected result written in the row
    addr_t                       want;
  } pixel_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [rbr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rbr_pkg::DIM_CFG_W-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic [rbr_pkg::PIXEL_W-1:0] pixel_x = '0;
  logic [rbr_pkg::PIXEL_W-1:0] pixel_y = '0;
  logic out_valid;
  logic out_ready = 0;
  logic inside_res;
  logic [rbr_pkg::COORD_W-1:0] source_x;
  logic [rbr_pkg::COORD_W-1:0] source_y;
  logic [rbr_pkg::INDEX_W-1:0] source_index;

  radial_barrel_remap_address_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .out_valid(out_valid), .out_ready(out_ready),
    .inside_res(inside_res), .source_x(source_x),
    .source_y(source_y), .source_index(source_index)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // shadow of the size registers as the block sees them
  logic [rbr_pkg::DIM_CFG_W-1:0] width_reg = rbr_pkg::WIDTH_RESET;
  logic [rbr_pkg::DIM_CFG_W-1:0] height_reg = rbr_pkg::HEIGHT_RESET;

  addr_t pending_addr[$];
  int    errors = 0;
  int    beats_checked = 0;
  int    outside_seen = 0;
  int    bound_miss_seen = 0;
  bit    drain_hold = 0;  // receiver keeps ready high while this is set

  function automatic longint unsigned usable_dim(logic [rbr_pkg::DIM_CFG_W-1:0] d);
    if (d == 0) return 1;
    if (d > DIM_MAX) return DIM_MAX;
    return longint'(d);
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint centred(longint unsigned p, longint unsigned d);
    longint unsigned q;
    q = ((p * 2) << FRAC) / d;
    return longint'(q) - (longint'(1) << FRAC);
  endfunction

  function automatic longint bend_axis(longint unsigned nr, longint n, longint unsigned r);
    longint unsigned mag;
    longint v;
    mag = (n < 0) ? longint'(-n) : n;
    v = longint'((nr * mag) / r);
    return (n < 0) ? -v : v;
  endfunction

  // fisheye source address for one destination pixel
  function automatic addr_t fisheye_source(logic [rbr_pkg::PIXEL_W-1:0] px,
                                           logic [rbr_pkg::PIXEL_W-1:0] py);
    longint unsigned w, h, r2, r, s, nr, sx, sy, lin, one2;
    longint one, nx, ny, nxn, nyn;
    addr_t a;
    w = usable_dim(width_reg);
    h = usable_dim(height_reg);
    one = longint'(1) << FRAC;
    one2 = 64'd1 << (2*FRAC);
    nx = centred(px, w);
    ny = centred(py, h);
    a = '0;
    nxn = 0;
    nyn = 0;
    if (nx > one || ny > one) return a;
    r2 = longint'(nx*nx) + longint'(ny*ny);
    if (r2 > one2) return a;
    r = int_root(r2);
    s = int_root(one2 - r2);
    nr = (r + one - s) >> 1;
    if (r != 0) begin
      nxn = bend_axis(nr, nx, r);
      nyn = bend_axis(nr, ny, r);
    end
    sx = (longint'(nxn + one) * w) >> (FRAC+1);
    sy = (longint'(nyn + one) * h) >> (FRAC+1);
    lin = sy * w + sx;
    a.hit = lin < w*h;
    a.sx = sx[rbr_pkg::COORD_W-1:0];
    a.sy = sy[rbr_pkg::COORD_W-1:0];
    a.idx = lin[rbr_pkg::INDEX_W-1:0];
    return a;
  endfunction

  // sender idles between beats, valid drops only for a real gap
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 :
        ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic write_size(logic [rbr_pkg::CFG_IDX_W-1:0] which,
                            logic [rbr_pkg::DIM_CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= which;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (which == rbr_pkg::REG_IMAGE_WIDTH) width_reg = val;
    else width_reg = width_reg;
    if (which == rbr_pkg::REG_IMAGE_HEIGHT) height_reg = val;
    @(posedge clk);
  endtask

  // one pixel beat; expectation queued at acceptance, valid left high
  task automatic send_pixel(logic [rbr_pkg::PIXEL_W-1:0] px,
                            logic [rbr_pkg::PIXEL_W-1:0] py,
                            bit typed, addr_t want);
    addr_t calc;
    calc = fisheye_source(px, py);
    if (typed && calc !== want)
      $display("%0t table row (%0d,%0d) disagrees with predictor: row %h calc %h",
               $time, px, py, want, calc);
    pixel_x <= px;
    pixel_y <= py;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    pending_addr.push_back(typed ? want : calc);
  endtask

  task automatic wait_drained();
    in_valid <= 0;
    drain_hold = 1;
    while (pending_addr.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    drain_hold = 0;
  endtask

  // random pixel mostly inside the image, some beyond it and along the edges
  task automatic random_pixels(int count);
    logic [rbr_pkg::PIXEL_W-1:0] px, py;
    longint unsigned w, h;
    int k;
    w = usable_dim(width_reg);
    h = usable_dim(height_reg);
    for (k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: begin
          px = rbr_pkg::PIXEL_W'($urandom);
          py = rbr_pkg::PIXEL_W'($urandom);
        end
        1: begin
          px = ($urandom_range(0, 1) != 0) ? '0 :
               rbr_pkg::PIXEL_W'(w > 4096 ? 4095 : w - 1);
          py = rbr_pkg::PIXEL_W'($urandom_range(0, h > 4096 ? 4095 : h - 1));
        end
        default: begin
          px = rbr_pkg::PIXEL_W'($urandom_range(0, w > 4096 ? 4095 : w - 1));
          py = rbr_pkg::PIXEL_W'($urandom_range(0, h > 4096 ? 4095 : h - 1));
        end
      endcase
      send_pixel(px, py, 0, '0);
      if ($urandom_range(0, 3) == 0) idle_gap();
    end
  endtask

  // receiver: random back-pressure, compare each beat with the oldest entry
  initial begin
    addr_t want;
    addr_t got;
    int n;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got = '{inside_res, source_x, source_y, source_index};
        if (pending_addr.size() == 0) begin
          errors++;
          $display("%0t unexpected beat %h", $time, got);
        end else begin
          want = pending_addr.pop_front();
          beats_checked++;
          if (!want.hit) outside_seen++;
          if (!want.hit && want.sx != 0) bound_miss_seen++;
          if (got.hit !== want.hit) begin
            errors++;
            $display("%0t inside_res exp %0d got %0d", $time, want.hit, got.hit);
          end
          if (got.sx !== want.sx) begin
            errors++;
            $display("%0t source_x exp %0d got %0d", $time, want.sx, got.sx);
          end
          if (got.sy !== want.sy) begin
            errors++;
            $display("%0t source_y exp %0d got %0d", $time, want.sy, got.sy);
          end
          if (got.idx !== want.idx) begin
            errors++;
            $display("%0t source_index exp %0d got %0d", $time, want.idx, got.idx);
          end
        end
      end
      // an occasional long stall
      if (!drain_hold && $urandom_range(0, 199) == 0) begin
        n = $urandom_range(10, 60);
        out_ready <= 0;
        repeat (n) @(posedge clk);
        out_ready <= 1;
      end else if (drain_hold || $urandom_range(0, 3) != 0) begin
        out_ready <= 1;
      end else begin
        out_ready <= 0;
      end
    end
  end

  pixel_row_t dir_rows[$];

  initial begin
    pixel_row_t row;
    int k;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed rows at reset size 640x480
    dir_rows.push_back('{12'd320, 12'd240, 1, '{1'b1, 13'd320, 13'd240, 24'd153920}});
    dir_rows.push_back('{12'd0, 12'd0, 1, '0});            // corner, outside circle
    dir_rows.push_back('{12'd4095, 12'd4095, 1, '0});      // beyond configured size
    dir_rows.push_back('{12'd4095, 12'd0, 1, '0});
    dir_rows.push_back('{12'd0, 12'd240, 0, '0});          // left edge on circle
    dir_rows.push_back('{12'd639, 12'd240, 0, '0});
    dir_rows.push_back('{12'd320, 12'd0, 0, '0});
    dir_rows.push_back('{12'd320, 12'd479, 0, '0});
    dir_rows.push_back('{12'd100, 12'd100, 0, '0});
    dir_rows.push_back('{12'd500, 12'd400, 0, '0});
    dir_rows.push_back('{12'd2730, 12'd1365, 0, '0});
    dir_rows.push_back('{12'd321, 12'd241, 0, '0});
    dir_rows.push_back('{12'd319, 12'd239, 0, '0});
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_pixel(row.px, row.py, row.typed, row.want);
    end
    wait_drained();

    // zero size is used as one: no pixel lies inside the circle then
    write_size(rbr_pkg::REG_IMAGE_WIDTH, 13'd0);
    write_size(rbr_pkg::REG_IMAGE_HEIGHT, 13'd0);
    send_pixel(12'd0, 12'd0, 0, '0);
    send_pixel(12'd1, 12'd0, 1, '0);
    send_pixel(12'd4095, 12'd4095, 1, '0);
    random_pixels(20);
    wait_drained();

    // largest register value, clamped to the maximum dimension
    write_size(rbr_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
    write_size(rbr_pkg::REG_IMAGE_HEIGHT, 13'd4096);
    send_pixel(12'd2048, 12'd2048, 0, '0);
    send_pixel(12'd4095, 12'd2048, 0, '0);
    send_pixel(12'd0, 12'd2048, 0, '0);
    random_pixels(200);
    wait_drained();

    // several random sizes, small ones favoured
    for (k = 0; k < 8; k++) begin
      write_size(rbr_pkg::REG_IMAGE_WIDTH, rbr_pkg::DIM_CFG_W'((k % 2) ?
                 $urandom_range(1, 64) : $urandom_range(1, 4096)));
      write_size(rbr_pkg::REG_IMAGE_HEIGHT, rbr_pkg::DIM_CFG_W'((k % 3) ?
                 $urandom_range(1, 64) : $urandom_range(1, 4096)));
      random_pixels(180);
      wait_drained();
    end

    // an odd shape, then back to reset size for a final burst
    write_size(rbr_pkg::REG_IMAGE_WIDTH, 13'd1);
    write_size(rbr_pkg::REG_IMAGE_HEIGHT, 13'd4095);
    random_pixels(60);
    wait_drained();
    write_size(rbr_pkg::REG_IMAGE_WIDTH, rbr_pkg::WIDTH_RESET);
    write_size(rbr_pkg::REG_IMAGE_HEIGHT, rbr_pkg::HEIGHT_RESET);
    random_pixels(200);

    wait_drained();
    $display("checked %0d source address beats over 13 size settings", beats_checked);
    $display("%0d beats black or out of bounds, %0d with an index bound miss",
             outside_seen, bound_miss_seen);
    if (errors == 0) begin
      $display("radial_barrel_remap_address_unit verification clean");
    end else begin
      $display("radial_barrel_remap_address_unit verification failed");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #(20 * 400000);
    $display("radial_barrel_remap_address_unit verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rbr_pkg.sv
rtl/rbr_div_cell.sv
rtl/rbr_sqrt_cell.sv
rtl/radial_barrel_remap_address_unit.sv
test/testbench.sv
